### rtl/core/dct2d_pkg.sv
// Shared types, constants and the cosine table of the 8x8 block transform.
`default_nettype none
package dct2d_pkg;

    localparam int BLOCK_SIZE     = 8;
    localparam int IDX_W          = 3;
    localparam int COEF_FRAC_BITS = 14;
    localparam int MID_FRAC       = 6;
    localparam int SAMPLE_W       = 16;
    localparam int COEF_W         = 16;
    localparam int MID_W          = 24;
    localparam int PROD_W         = MID_W + COEF_W;
    localparam int ACC_W          = PROD_W + 2;
    localparam int LD_ADDR_W      = 2 * IDX_W + 1;
    localparam int TP_ADDR_W      = 2 * IDX_W;
    localparam int RND_ONE        = COEF_FRAC_BITS - MID_FRAC;
    localparam int RND_TWO        = COEF_FRAC_BITS + MID_FRAC;

    // Scaled cosine magnitudes alpha(u)*cos(j*pi/16) in Q1.14 for u > 0.
    localparam logic [COEF_W-1:0] COS_MAG [0:8] = '{
        16'd8192, 16'd8035, 16'd7568, 16'd6811, 16'd5793,
        16'd4551, 16'd3135, 16'd1598, 16'd0
    };
    localparam logic [COEF_W-1:0] DC_MAG = 16'd5793;

    localparam logic [2:0] CFG_ADDR_MODE = 3'd0;

    typedef struct packed {
        logic                     en;
        logic [LD_ADDR_W-1:0]     addr;
        logic signed [SAMPLE_W-1:0] data;
    } t_ld_wr;

    typedef struct packed {
        logic vld;
        logic bank;
        logic inv;
    } t_job;

    // Table entry A[u][x] with the cosine sign taken from the quadrant.
    function automatic logic signed [COEF_W-1:0] coef_val(input logic [IDX_W-1:0] u,
                                                          input logic [IDX_W-1:0] x);
        logic [6:0]        prod;
        logic [4:0]        m;
        logic [1:0]        q;
        logic [3:0]        j;
        logic [COEF_W-1:0] mag;
        logic              neg;
        prod = 7'({3'b0, x, 1'b1} * {4'b0, u});
        m    = prod[4:0];
        q    = m[4:3];
        j    = q[0] ? (4'd8 - {1'b0, m[2:0]}) : {1'b0, m[2:0]};
        neg  = (q == 2'd1) || (q == 2'd2);
        mag  = (u == '0) ? DC_MAG : COS_MAG[j];
        return neg ? -$signed(mag) : $signed(mag);
    endfunction

endpackage
`default_nettype wire

### rtl/core/dct2d_front.sv
// Input side: load counter, bank selection and the queue of finished blocks.
`default_nettype none
module dct2d_front (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic signed [dct2d_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic                              i_inverse_mode,
    output dct2d_pkg::t_ld_wr                      o_ld_wr,
    output dct2d_pkg::t_job                        o_job,
    input  wire logic                              i_pop
);
    import dct2d_pkg::*;

    logic [2*IDX_W-1:0] r_load_cnt;
    logic               r_wr_bank;
    logic [1:0]         r_q_cnt;
    logic               r_q_rd;
    logic               r_q_wr;
    logic               r_q_bank [2];
    logic               r_q_inv  [2];
    logic               accept;
    logic               push;

    // Two load banks: a block may be loaded while the other one is read.
    assign o_in_stall = (r_q_cnt == 2'd2);
    assign accept     = i_in_valid && !o_in_stall;
    assign push       = accept && (r_load_cnt == '1);

    assign o_ld_wr.en   = accept;
    assign o_ld_wr.addr = {r_wr_bank, r_load_cnt};
    assign o_ld_wr.data = i_sample;

    assign o_job.vld  = (r_q_cnt != 2'd0);
    assign o_job.bank = r_q_bank[r_q_rd];
    assign o_job.inv  = r_q_inv[r_q_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_cnt <= '0;
            r_wr_bank  <= 1'b0;
            r_q_cnt    <= 2'd0;
            r_q_rd     <= 1'b0;
            r_q_wr     <= 1'b0;
        end else begin
            if (accept) begin
                r_load_cnt <= r_load_cnt + 1'b1;
            end
            if (push) begin
                r_wr_bank <= !r_wr_bank;
                r_q_wr    <= !r_q_wr;
            end
            if (i_pop) begin
                r_q_rd <= !r_q_rd;
            end
            r_q_cnt <= r_q_cnt + {1'b0, push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_bank[r_q_wr] <= r_wr_bank;
            r_q_inv[r_q_wr]  <= i_inverse_mode;
        end
    end

    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_cnt <= 2'd2)
        else $error("block queue overflow");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_q_cnt != 2'd0))
        else $error("pop from empty block queue");
    a_bank_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && r_q_cnt == 2'd1) |-> (r_wr_bank != r_q_bank[r_q_rd]))
        else $error("load bank still in use");

endmodule
`default_nettype wire

### rtl/core/dct2d_back.sv
// Transform engine: load and transpose memories, one MAC pipeline, result queue.
`default_nettype none
module dct2d_back (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire dct2d_pkg::t_ld_wr                 i_ld_wr,
    input  wire dct2d_pkg::t_job                   i_job,
    output logic                                   o_pop,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic signed [dct2d_pkg::COEF_W-1:0]    o_coefficient,
    output logic [dct2d_pkg::IDX_W-1:0]            o_out_row,
    output logic [dct2d_pkg::IDX_W-1:0]            o_out_col,
    output logic                                   o_block_end
);
    import dct2d_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_PASS1 = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_PASS2 = 4'b1000
    } t_state;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic                     last;
    } t_res;

    localparam int FIFO_D = 4;

    t_state r_state, n_state;
    logic [IDX_W-1:0] r_i, r_j, r_k, n_i, n_j, n_k;
    logic r_bank, r_inv;
    logic issue, last_op, credit_ok;

    logic signed [SAMPLE_W-1:0] ld_mem [2*BLOCK_SIZE*BLOCK_SIZE];
    logic signed [MID_W-1:0]    tp_mem [BLOCK_SIZE*BLOCK_SIZE];
    logic signed [SAMPLE_W-1:0] r_ld_q;
    logic signed [MID_W-1:0]    r_tp_q;

    logic                     r_s1_vld, r_s1_p2, r_s1_first, r_s1_last;
    logic [IDX_W-1:0]         r_s1_i, r_s1_j;
    logic signed [COEF_W-1:0] r_s1_coef;
    logic                     r_s2_vld, r_s2_p2, r_s2_first, r_s2_last;
    logic [IDX_W-1:0]         r_s2_i, r_s2_j;
    logic signed [PROD_W-1:0] r_s2_prod;
    logic                     r_s3_vld, r_s3_p2;
    logic [IDX_W-1:0]         r_s3_i, r_s3_j;
    logic signed [ACC_W-1:0]  r_acc;

    logic [IDX_W-1:0]         cu, cx;
    logic signed [MID_W-1:0]  operand;
    logic signed [ACC_W-1:0]  rnd1, rnd2;
    logic signed [MID_W-1:0]  mid_val;
    logic signed [COEF_W-1:0] out_val;

    t_res             r_fifo [FIFO_D];
    logic [1:0]       r_f_wr, r_f_rd;
    logic [2:0]       r_f_cnt, r_inflight;
    logic             f_push, f_pop, start_elem;

    // Sequencer over (i, j, k) with k innermost.
    assign last_op = (r_i == '1) && (r_j == '1) && (r_k == '1);
    assign credit_ok = ({1'b0, r_f_cnt} + {1'b0, r_inflight}) < 4'(FIFO_D);

    always_comb begin
        n_state = r_state;
        n_i = r_i;
        n_j = r_j;
        n_k = r_k;
        issue = 1'b0;
        o_pop = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_job.vld) begin
                    n_state = ST_PASS1;
                    n_i = '0;
                    n_j = '0;
                    n_k = '0;
                end
            end
            ST_PASS1: begin
                issue = 1'b1;
                if (last_op) begin
                    o_pop   = 1'b1;
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_s1_vld && !r_s2_vld && !r_s3_vld) begin
                    n_state = ST_PASS2;
                    n_i = '0;
                    n_j = '0;
                    n_k = '0;
                end
            end
            ST_PASS2: begin
                issue = (r_k != '0) || credit_ok;
                if (issue && last_op) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        if (issue) begin
            n_k = r_k + 1'b1;
            if (r_k == '1) begin
                n_j = r_j + 1'b1;
                if (r_j == '1) begin
                    n_i = r_i + 1'b1;
                end
            end
        end
    end

    assign start_elem = issue && (r_state == ST_PASS2) && (r_k == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_i <= n_i;
        r_j <= n_j;
        r_k <= n_k;
        if (r_state == ST_IDLE && i_job.vld) begin
            r_bank <= i_job.bank;
            r_inv  <= i_job.inv;
        end
    end

    // Memories with registered reads.
    always_ff @(posedge i_clk) begin
        if (i_ld_wr.en) begin
            ld_mem[i_ld_wr.addr] <= i_ld_wr.data;
        end
        r_ld_q <= ld_mem[{r_bank, r_k, r_j}];
        if (r_s3_vld && !r_s3_p2) begin
            tp_mem[{r_s3_i, r_s3_j}] <= mid_val;
        end
        r_tp_q <= tp_mem[{r_i, r_k}];
    end

    // Coefficient row index is i in the first pass and j in the second; inverse mode swaps row and column.
    always_comb begin
        cu = (r_state == ST_PASS2) ? r_j : r_i;
        cx = r_k;
        if (r_inv) begin
            cu = r_k;
            cx = (r_state == ST_PASS2) ? r_j : r_i;
        end
    end

    assign operand = r_s1_p2 ? r_tp_q : MID_W'(r_ld_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            r_s1_vld <= issue;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld && r_s2_last;
        end
        r_s1_p2    <= (r_state == ST_PASS2);
        r_s1_first <= (r_k == '0);
        r_s1_last  <= (r_k == '1);
        r_s1_i     <= r_i;
        r_s1_j     <= r_j;
        r_s1_coef  <= coef_val(cu, cx);
        r_s2_p2    <= r_s1_p2;
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
        r_s2_i     <= r_s1_i;
        r_s2_j     <= r_s1_j;
        r_s2_prod  <= operand * r_s1_coef;
        if (r_s2_vld) begin
            r_acc <= (r_s2_first ? '0 : r_acc) + ACC_W'(r_s2_prod);
        end
        r_s3_p2 <= r_s2_p2;
        r_s3_i  <= r_s2_i;
        r_s3_j  <= r_s2_j;
    end

    // Round half up, then saturate.
    always_comb begin
        rnd1 = (r_acc + (ACC_W'(1) <<< (RND_ONE - 1))) >>> RND_ONE;
        rnd2 = (r_acc + (ACC_W'(1) <<< (RND_TWO - 1))) >>> RND_TWO;
        if (rnd1 > ACC_W'((1 <<< (MID_W - 1)) - 1)) begin
            mid_val = {1'b0, {(MID_W-1){1'b1}}};
        end else if (rnd1 < -ACC_W'(1 <<< (MID_W - 1))) begin
            mid_val = {1'b1, {(MID_W-1){1'b0}}};
        end else begin
            mid_val = rnd1[MID_W-1:0];
        end
        if (rnd2 > ACC_W'((1 <<< (COEF_W - 1)) - 1)) begin
            out_val = {1'b0, {(COEF_W-1){1'b1}}};
        end else if (rnd2 < -ACC_W'(1 <<< (COEF_W - 1))) begin
            out_val = {1'b1, {(COEF_W-1){1'b0}}};
        end else begin
            out_val = rnd2[COEF_W-1:0];
        end
    end

    // Result queue; new second-pass elements start only against free slots.
    assign f_push = r_s3_vld && r_s3_p2;
    assign f_pop  = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_wr     <= '0;
            r_f_rd     <= '0;
            r_f_cnt    <= '0;
            r_inflight <= '0;
        end else begin
            if (f_push) begin
                r_f_wr <= r_f_wr + 1'b1;
            end
            if (f_pop) begin
                r_f_rd <= r_f_rd + 1'b1;
            end
            r_f_cnt    <= r_f_cnt + {2'b0, f_push} - {2'b0, f_pop};
            r_inflight <= r_inflight + {2'b0, start_elem} - {2'b0, f_push};
        end
        if (f_push) begin
            r_fifo[r_f_wr] <= '{coef: out_val, row: r_s3_i, col: r_s3_j,
                                last: (r_s3_i == '1) && (r_s3_j == '1)};
        end
    end

    assign o_out_valid   = (r_f_cnt != '0);
    assign o_coefficient = r_fifo[r_f_rd].coef;
    assign o_out_row     = r_fifo[r_f_rd].row;
    assign o_out_col     = r_fifo[r_f_rd].col;
    assign o_block_end   = r_fifo[r_f_rd].last;

    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_f_cnt} + {1'b0, r_inflight}) <= 4'(FIFO_D))
        else $error("result queue overcommitted");
    a_pass1_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PASS2) |-> !(r_s3_vld && !r_s3_p2))
        else $error("first pass still writing during second pass");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_push |-> (r_f_cnt < 3'(FIFO_D) || f_pop))
        else $error("result queue overflow");

endmodule
`default_nettype wire

### rtl/core/dct2d_block_transform_core.sv
// Top level of the 8x8 orthonormal 2-D DCT-II / DCT-III block transform.
`default_nettype none
// The core takes a block of 64 signed 16-bit samples in row-major order, one
// per input transfer, and after the last sample returns the 64 transformed
// values in row-major order with row and column indices; the final value of
// the block carries block_end. Register 0 (byte address 0, bit 0) selects the
// forward DCT-II when 0 or the inverse DCT-III when 1; its value is captured
// with the last sample of each block. The front end writes samples into one
// of two load banks at one transfer per cycle, so a new block can be loaded
// while the previous one is transformed; it stalls only when both banks hold
// blocks not yet read. The back end has a single multiply-accumulate unit:
// the column pass is followed by a drain of the pipeline and then the row
// pass, which starts a new value only while the result queue has room. The
// sustained rate is therefore set by that one MAC unit. Results are rounded
// half up and saturated to 16 bits.
module dct2d_block_transform_core (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire logic signed [dct2d_pkg::SAMPLE_W-1:0] i_sample,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output logic signed [dct2d_pkg::COEF_W-1:0]       o_coefficient,
    output logic [dct2d_pkg::IDX_W-1:0]               o_out_row,
    output logic [dct2d_pkg::IDX_W-1:0]               o_out_col,
    output logic                                      o_block_end,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [2:0]                           paddr,
    input  wire logic [31:0]                          pwdata,
    output logic [31:0]                               prdata,
    output logic                                      pready
);
    import dct2d_pkg::*;

    logic   r_inverse_mode;
    t_ld_wr ld_wr;
    t_job   job;
    logic   pop;

    // The register file is a single mode bit; writes land in one access.
    assign pready = 1'b1;
    assign prdata = (paddr == CFG_ADDR_MODE) ? {31'b0, r_inverse_mode} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inverse_mode <= 1'b0;
        end else if (psel && penable && pwrite && pready && paddr == CFG_ADDR_MODE) begin
            r_inverse_mode <= pwdata[0];
        end
    end

    dct2d_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample       (i_sample),
        .i_inverse_mode (r_inverse_mode),
        .o_ld_wr        (ld_wr),
        .o_job          (job),
        .i_pop          (pop)
    );

    dct2d_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ld_wr       (ld_wr),
        .i_job         (job),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_coefficient (o_coefficient),
        .o_out_row     (o_out_row),
        .o_out_col     (o_out_col),
        .o_block_end   (o_block_end)
    );

endmodule
`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for the 8x8 forward and inverse DCT block transform core.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dct2d_pkg::*;

    localparam int NN        = BLOCK_SIZE * BLOCK_SIZE;
    localparam int DRAIN_CYC = 1200;   // A bit more than one full transform.
    localparam int HOLD_CYC  = 3000;   // Long receiver hold-off that fills the result queue.
    localparam logic [2:0] ADDR_SPARE = 3'd4;

    typedef struct {
        logic signed [COEF_W-1:0] coefficient;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic                     block_end;
    } t_coef_out;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic signed [SAMPLE_W-1:0] i_sample;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic signed [COEF_W-1:0]   o_coefficient;
    logic [IDX_W-1:0]           o_out_row;
    logic [IDX_W-1:0]           o_out_col;
    logic                       o_block_end;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [2:0]                 paddr;
    logic [31:0]                pwdata;
    logic [31:0]                prdata;
    logic                       pready;

    dct2d_block_transform_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_sample      (i_sample),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_coefficient (o_coefficient),
        .o_out_row     (o_out_row),
        .o_out_col     (o_out_col),
        .o_block_end   (o_block_end),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Free-running 100 MHz clock.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Cosine table in the same fixed-point form as the hardware: signed Q1.14.
    longint   cos_tab [BLOCK_SIZE][BLOCK_SIZE];
    // Mirror of the mode register and of the block being loaded.
    logic     mode_inverse;
    longint   load_img [NN];
    int       load_cnt;

    t_coef_out coef_fifo [$];
    int        mismatches;
    int        unexpected;
    bit        hold_req;
    bit        stim_done;

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Taylor-series cosine of j*pi/(2N) in Q30, each term truncated.
    function automatic longint unsigned cos_fixed(input longint unsigned j);
        longint unsigned theta;
        longint unsigned x2;
        longint unsigned mag;
        longint          acc;
        theta = j * 64'hC90FDAA2 / (2 * BLOCK_SIZE);
        x2    = (theta * theta) >> 30;
        mag   = 64'd1 << 30;
        acc   = longint'(64'd1 << 30);
        for (int k = 1; k <= 10; k++) begin
            mag = ((mag * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
            if (k % 2 == 1) acc = acc - longint'(mag);
            else            acc = acc + longint'(mag);
        end
        if (acc < 0) acc = 0;
        if (acc > longint'(64'd1 << 30)) acc = longint'(64'd1 << 30);
        return longint'(acc);
    endfunction

    function automatic void build_cos_tab();
        longint unsigned dc_scale;
        longint unsigned ac_scale;
        longint unsigned m, q, r, j, p, v;
        dc_scale = int_sqrt((64'd1 << 60) / BLOCK_SIZE);
        ac_scale = int_sqrt((64'd1 << 61) / BLOCK_SIZE);
        for (int u = 0; u < BLOCK_SIZE; u++) begin
            for (int x = 0; x < BLOCK_SIZE; x++) begin
                m = ((2 * x + 1) * u) % (4 * BLOCK_SIZE);
                q = m / BLOCK_SIZE;
                r = m % BLOCK_SIZE;
                j = q[0] ? BLOCK_SIZE - r : r;
                p = ((u == 0) ? dc_scale : ac_scale) * cos_fixed(j);
                v = (p + (64'd1 << (59 - COEF_FRAC_BITS))) >> (60 - COEF_FRAC_BITS);
                cos_tab[u][x] = (q == 1 || q == 2) ? -longint'(v) : longint'(v);
            end
        end
    endfunction

    // Round half up by s bits (floor of t/2^s + 1/2), then clamp to a signed width.
    function automatic longint round_sat(input longint t, input int s, input int bits);
        longint v;
        longint hi;
        v  = (t + (longint'(1) <<< (s - 1))) >>> s;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        if (v > hi) v = hi;
        if (v < -hi - 1) v = -hi - 1;
        return v;
    endfunction

    function automatic longint tab_entry(input int a, input int b, input logic inv);
        return inv ? cos_tab[b][a] : cos_tab[a][b];
    endfunction

    // Two separable passes over the loaded block; queue all 64 coefficients.
    function automatic void transform_block(input logic inv);
        longint    mid [NN];
        longint    acc;
        t_coef_out c;
        for (int i = 0; i < BLOCK_SIZE; i++)
            for (int j = 0; j < BLOCK_SIZE; j++) begin
                acc = 0;
                for (int k = 0; k < BLOCK_SIZE; k++)
                    acc += tab_entry(i, k, inv) * load_img[k * BLOCK_SIZE + j];
                mid[i * BLOCK_SIZE + j] = round_sat(acc, RND_ONE, MID_W);
            end
        for (int i = 0; i < BLOCK_SIZE; i++)
            for (int j = 0; j < BLOCK_SIZE; j++) begin
                acc = 0;
                for (int k = 0; k < BLOCK_SIZE; k++)
                    acc += mid[i * BLOCK_SIZE + k] * tab_entry(j, k, inv);
                c.coefficient = COEF_W'(round_sat(acc, RND_TWO, COEF_W));
                c.row         = IDX_W'(i);
                c.col         = IDX_W'(j);
                c.block_end   = (i == BLOCK_SIZE - 1) && (j == BLOCK_SIZE - 1);
                coef_fifo.push_back(c);
            end
    endfunction

    // Load one sample into the mirror; the last sample of a block fires the transform.
    function automatic void accept_sample(input logic signed [SAMPLE_W-1:0] s);
        load_img[load_cnt] = longint'(s);
        load_cnt++;
        if (load_cnt == NN) begin
            load_cnt = 0;
            transform_block(mode_inverse);
        end
    endfunction

    // Offer one sample and hold it until the core takes the transfer.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_sample   = s;
        do @(posedge i_clk); while (o_in_stall);
        accept_sample(s);
    endtask

    // Sender gap: mostly none, sometimes short, rarely long.
    task automatic sender_gap();
        int gap;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)      gap = 0;
        else if (pick < 95) gap = $urandom_range(1, 4);
        else                gap = $urandom_range(10, 60);
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            i_sample   = SAMPLE_W'($urandom);
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == CFG_ADDR_MODE) mode_inverse = data[0];
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Stop offering samples until every queued coefficient has come out,
    // then let the back end settle before any register write.
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (coef_fifo.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] rand_sample(input int flavor);
        case (flavor)
            0: return SAMPLE_W'($urandom);
            1: return SAMPLE_W'($signed($urandom_range(0, 510)) - 255);
            2: return $urandom_range(0, 1) ? 16'sh7FFF : -16'sh8000;
            default: return $urandom_range(0, 3) == 0 ? SAMPLE_W'($urandom) : 16'sh7FF0;
        endcase
    endfunction

    task automatic send_block(input int flavor, input int from_idx);
        for (int n = from_idx; n < NN; n++) begin
            send_sample(rand_sample(flavor));
            sender_gap();
        end
    endtask

    // Directed opening of the first block: extremes, sign boundaries and
    // single bits walking through the sample.
    localparam int DIR_ROWS = 25;
    localparam logic signed [SAMPLE_W-1:0] DIR_SAMPLES [DIR_ROWS] = '{
        16'sh7FFF, -16'sh8000, 16'sh0000, 16'sh0001, -16'sh0001,
        16'sh5555, -16'sh5556, 16'sh7FFE, -16'sh7FFF, 16'sh0100,
        16'sh0002, 16'sh0004, 16'sh0008, 16'sh0010, 16'sh0020,
        16'sh0040, 16'sh0080, 16'sh0200, 16'sh0400, 16'sh0800,
        16'sh1000, 16'sh2000, 16'sh4000, 16'sh7FFF, -16'sh8000
    };

    // Stimulus and register programming.
    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_sample     = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        mode_inverse = 1'b0;
        load_cnt     = 0;
        hold_req     = 1'b0;
        stim_done    = 1'b0;
        build_cos_tab();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Block 0, forward mode out of reset: directed rows, then random fill.
        for (int r = 0; r < DIR_ROWS; r++) begin
            send_sample(DIR_SAMPLES[r]);
            sender_gap();
        end
        send_block(0, DIR_ROWS);

        // Block 1: inverse mode with saturating extremes.
        wait_idle();
        apb_write(CFG_ADDR_MODE, 32'hFFFF_FFFF);
        send_block(2, 0);

        // Block 2: the mode changes while the block is half loaded; only the
        // value present at the last sample counts. A write to the spare
        // address must leave the mode alone, and only bit 0 is used.
        wait_idle();
        apb_write(CFG_ADDR_MODE, 32'h0000_0000);
        for (int n = 0; n < 30; n++) begin
            send_sample(rand_sample(1));
            sender_gap();
        end
        wait_idle();
        apb_write(CFG_ADDR_MODE, 32'h0000_0001);
        apb_write(ADDR_SPARE, 32'h0000_0000);
        send_block(0, 30);

        wait_idle();
        apb_write(CFG_ADDR_MODE, 32'h0000_0002);
        // Blocks 3 and 4 go back to back while the receiver holds off, so the
        // result queue fills and block 4 waits in its load bank.
        hold_req = 1'b1;
        send_block(3, 0);
        send_block(0, 0);

        wait_idle();
        apb_write(CFG_ADDR_MODE, 32'h0000_0001);
        send_block(3, 0);

        @(negedge i_clk);
        i_in_valid = 1'b0;
        stim_done  = 1'b1;
    end

    // Receiver: random stall runs, one long hold-off, and the result check.
    initial begin
        int  run;
        bit  held;
        t_coef_out want;
        i_out_stall = 1'b0;
        mismatches  = 0;
        unexpected  = 0;
        run         = 0;
        held        = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !held) begin
                held        = 1'b1;
                i_out_stall = 1'b1;
                repeat (HOLD_CYC) @(negedge i_clk);
                i_out_stall = 1'b0;
            end else if (run > 0) begin
                run--;
            end else begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3:  begin i_out_stall = 1'b1; run = $urandom_range(0, 3);  end
                    4:           begin i_out_stall = 1'b1; run = $urandom_range(8, 40); end
                    5:           begin i_out_stall = 1'b0; run = $urandom_range(50, 200); end
                    default:     i_out_stall = 1'b0;
                endcase
            end
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) begin
                if (coef_fifo.size() == 0) begin
                    unexpected++;
                    if (mismatches + unexpected <= 10)
                        $display("Unexpected coefficient %0d at row %0d col %0d",
                                 o_coefficient, o_out_row, o_out_col);
                end else begin
                    want = coef_fifo.pop_front();
                    if (o_coefficient !== want.coefficient || o_out_row !== want.row ||
                        o_out_col !== want.col || o_block_end !== want.block_end) begin
                        mismatches++;
                        if (mismatches + unexpected <= 10)
                            $display("Mismatch: expected %0d r%0d c%0d end%0b, got %0d r%0d c%0d end%0b",
                                     want.coefficient, want.row, want.col, want.block_end,
                                     o_coefficient, o_out_row, o_out_col, o_block_end);
                    end
                end
            end
        end
    end

    // End of run: all queued results out, then one more transform time of quiet.
    initial begin
        wait (stim_done);
        while (coef_fifo.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (mismatches == 0 && unexpected == 0 && coef_fifo.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
`default_nettype wire

### files.f
rtl/core/dct2d_pkg.sv
rtl/core/dct2d_front.sv
rtl/core/dct2d_back.sv
rtl/core/dct2d_block_transform_core.sv
verif/testbench.sv
